@@ src/lphs_pkg.sv @@
// lphs_pkg: widths, operation codes, status codes and slot marks of the hash set
// no dependencies; used by the channel interfaces and the top level
package lphs_pkg;

	localparam int CMD_W = 2;
	localparam int KEY_W = 32;
	localparam int HASH_W = 32;
	localparam int STATUS_W = 3;
	localparam int SLOT_OUT_W = 8;
	localparam int CFG_W = 9;
	localparam int MARK_W = 2;

	// remainder unit: bits of the hash folded in per cycle
	localparam int DIV_STEP = 4;
	localparam int DIV_CYCLES = HASH_W / DIV_STEP;
	localparam int DIV_CNT_W = $clog2(DIV_CYCLES);

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [KEY_W-1:0] key_t;
	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [SLOT_OUT_W-1:0] slot_out_t;
	typedef logic [MARK_W-1:0] mark_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_CONTAINS = 2'd1;
	localparam cmd_t CMD_REMOVE = 2'd2;

	localparam status_t ST_INSERTED = 3'd0;
	localparam status_t ST_PRESENT = 3'd1;
	localparam status_t ST_FULL = 3'd2;
	localparam status_t ST_FOUND = 3'd3;
	localparam status_t ST_NOT_FOUND = 3'd4;
	localparam status_t ST_REMOVED = 3'd5;

	localparam mark_t MARK_EMPTY = 2'd0;
	localparam mark_t MARK_USED = 2'd1;
	localparam mark_t MARK_TOMB = 2'd2;

	localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 9'd256;

endpackage

@@ src/lphs_req_if.sv @@
// lphs_req_if: request channel of the hash set (operation, key, hash)
// depends on lphs_pkg
interface lphs_req_if;
	logic valid;
	logic ready;
	lphs_pkg::cmd_t cmd;
	lphs_pkg::key_t key;
	lphs_pkg::hash_t hash_value;

	modport source (output valid, output cmd, output key, output hash_value, input ready);
	modport sink (input valid, input cmd, input key, input hash_value, output ready);
endinterface

@@ src/lphs_rsp_if.sv @@
// lphs_rsp_if: response channel of the hash set (status, slot index)
// depends on lphs_pkg
interface lphs_rsp_if;
	logic valid;
	logic ready;
	lphs_pkg::status_t status;
	lphs_pkg::slot_out_t slot_index;

	modport source (output valid, output status, output slot_index, input ready);
	modport sink (input valid, input status, input slot_index, output ready);
endinterface

@@ src/linear_probe_hash_set_unit.sv @@
// Hash set of 32-bit keys over SLOTS slots, linear probing with tombstones.
// One item is worked at a time. An accepted item passes the remainder
// unit (hash modulo table size, 4 bits a cycle), then the home-slot read,
// then the probe of the slot memory (one write and one registered read
// port), slot after slot, and then the step that hands the result to the
// output register. The probe visits 1..table size slots.
// The request side is ready again once the result sits in the output
// register. After reset a clearing pass over all SLOTS slots marks every slot
// empty; no item is accepted during it, table_size writes are taken anytime.
// table_size 0 acts as 1 and values above SLOTS act as SLOTS.
// depends on lphs_pkg, lphs_req_if, lphs_rsp_if
module linear_probe_hash_set_unit #(
	parameter int SLOTS = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [lphs_pkg::CFG_W-1:0] cfg_wr_data,
	lphs_req_if.sink                   req,
	lphs_rsp_if.source                 rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int NW = (IW + 1 > lphs_pkg::CFG_W) ? IW + 1 : lphs_pkg::CFG_W;
	localparam int WW = lphs_pkg::MARK_W + lphs_pkg::KEY_W;

	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DIV = 3'd2;
	localparam logic [2:0] S_HOME = 3'd3;
	localparam logic [2:0] S_PROBE = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic [lphs_pkg::CFG_W-1:0] table_size_q;
	logic [IW-1:0] clr_q;
	logic [lphs_pkg::DIV_CNT_W-1:0] div_cnt_q;

	lphs_pkg::cmd_t cmd_q;
	lphs_pkg::key_t key_q;
	lphs_pkg::hash_t hv_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] rem_q;
	logic [IW-1:0] cur_q;
	logic [NW-1:0] cnt_q;
	logic free_vld_q;
	logic [IW-1:0] free_q;

	lphs_pkg::status_t res_status_q;
	lphs_pkg::slot_out_t res_slot_q;
	logic out_vld_q;
	lphs_pkg::status_t out_status_q;
	lphs_pkg::slot_out_t out_slot_q;

	logic [WW-1:0] mem [SLOTS];
	logic [WW-1:0] rd_q;

	logic [NW-1:0] ts_ext;
	logic [NW-1:0] n_live;
	logic [NW-1:0] rem_next;
	logic [IW-1:0] nxt;
	logic [IW-1:0] rd_addr;
	logic mem_we;
	logic [IW-1:0] wr_addr;
	logic [WW-1:0] wr_data;

	lphs_pkg::mark_t rd_mark;
	lphs_pkg::key_t rd_key;
	logic is_empty;
	logic is_hit;
	logic is_last;
	logic probe_end;
	logic fv;
	logic [IW-1:0] fs;
	lphs_pkg::status_t end_status;
	logic [IW-1:0] end_slot;
	logic [IW+lphs_pkg::SLOT_OUT_W-1:0] slot_ext;
	logic slot_none;

	// effective table size, clamped to 1..SLOTS
	always_comb begin
		ts_ext = NW'(table_size_q);
		if (table_size_q == '0) begin
			n_live = NW'(1);
		end else if (ts_ext > NW'(SLOTS)) begin
			n_live = NW'(SLOTS);
		end else begin
			n_live = ts_ext;
		end
	end

	// remainder unit: restoring steps, DIV_STEP hash bits per cycle
	always_comb begin
		logic [NW:0] r2;
		rem_next = rem_q;
		for (int i = 0; i < lphs_pkg::DIV_STEP; i++) begin
			r2 = {rem_next, hv_q[lphs_pkg::HASH_W-1-i]};
			if (r2 >= {1'b0, n_q}) begin
				r2 = r2 - {1'b0, n_q};
			end
			rem_next = r2[NW-1:0];
		end
	end

	// next probe slot with wrap at the table size
	always_comb begin
		if (NW'(cur_q) + NW'(1) == n_q) begin
			nxt = '0;
		end else begin
			nxt = IW'(cur_q + IW'(1));
		end
	end

	// evaluation of the slot read back this cycle
	always_comb begin
		rd_mark = rd_q[WW-1 -: lphs_pkg::MARK_W];
		rd_key = rd_q[lphs_pkg::KEY_W-1:0];
		is_empty = (rd_mark == lphs_pkg::MARK_EMPTY);
		is_hit = (rd_mark == lphs_pkg::MARK_USED) && (rd_key == key_q);
		is_last = (cnt_q + NW'(1) == n_q);
		probe_end = is_empty || is_hit || is_last;
		fv = free_vld_q || (rd_mark != lphs_pkg::MARK_USED);
		fs = free_vld_q ? free_q : cur_q;
	end

	// result and slot write at the end of the probe
	always_comb begin
		end_status = lphs_pkg::ST_NOT_FOUND;
		end_slot = '0;
		mem_we = 1'b0;
		wr_addr = cur_q;
		wr_data = {lphs_pkg::MARK_TOMB, rd_key};
		case (cmd_q)
			lphs_pkg::CMD_INSERT: begin
				if (is_hit) begin
					end_status = lphs_pkg::ST_PRESENT;
					end_slot = cur_q;
				end else if (fv) begin
					end_status = lphs_pkg::ST_INSERTED;
					end_slot = fs;
					mem_we = 1'b1;
					wr_addr = fs;
					wr_data = {lphs_pkg::MARK_USED, key_q};
				end else begin
					end_status = lphs_pkg::ST_FULL;
				end
			end
			lphs_pkg::CMD_REMOVE: begin
				if (is_hit) begin
					end_status = lphs_pkg::ST_REMOVED;
					end_slot = cur_q;
					mem_we = 1'b1;
				end
			end
			default: begin
				if (is_hit) begin
					end_status = lphs_pkg::ST_FOUND;
					end_slot = cur_q;
				end
			end
		endcase
		if (state_q == S_CLR) begin
			mem_we = 1'b1;
			wr_addr = clr_q;
			wr_data = {lphs_pkg::MARK_EMPTY, lphs_pkg::key_t'(0)};
		end else if (!(state_q == S_PROBE && probe_end)) begin
			mem_we = 1'b0;
		end
	end

	assign slot_none = 1'b0;
	assign slot_ext = {{lphs_pkg::SLOT_OUT_W{slot_none}}, end_slot};
	assign rd_addr = (state_q == S_HOME) ? rem_q[IW-1:0] : nxt;

	// slot memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= lphs_pkg::TABLE_SIZE_RST;
		end else if (cfg_wr_en) begin
			table_size_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			div_cnt_q <= '0;
			free_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			// output register: load a finished item, or empty it when taken
			if (state_q == S_DONE && (!out_vld_q || rsp.ready)) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= IW'(clr_q + IW'(1));
					if (clr_q == IW'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_DIV;
						div_cnt_q <= '0;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + lphs_pkg::DIV_CNT_W'(1);
					if (div_cnt_q == lphs_pkg::DIV_CNT_W'(lphs_pkg::DIV_CYCLES - 1)) begin
						state_q <= S_HOME;
					end
				end
				S_HOME: begin
					free_vld_q <= 1'b0;
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (probe_end) begin
						state_q <= S_DONE;
					end else if (rd_mark != lphs_pkg::MARK_USED && !free_vld_q) begin
						free_vld_q <= 1'b1;
					end
				end
				S_DONE: begin
					if (!out_vld_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers of the item in work
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= req.cmd;
				key_q <= req.key;
				hv_q <= req.hash_value;
				n_q <= n_live;
				rem_q <= '0;
			end
			S_DIV: begin
				rem_q <= rem_next;
				hv_q <= hv_q << lphs_pkg::DIV_STEP;
			end
			S_HOME: begin
				cur_q <= rem_q[IW-1:0];
				cnt_q <= '0;
			end
			S_PROBE: begin
				if (!probe_end && rd_mark != lphs_pkg::MARK_USED && !free_vld_q) begin
					free_q <= cur_q;
				end
				cur_q <= nxt;
				cnt_q <= cnt_q + NW'(1);
				res_status_q <= end_status;
				res_slot_q <= slot_ext[lphs_pkg::SLOT_OUT_W-1:0];
			end
			S_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					out_status_q <= res_status_q;
					out_slot_q <= res_slot_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_vld_q;
	assign rsp.status = out_status_q;
	assign rsp.slot_index = out_slot_q;

endmodule
